// ----- hdl/tetacc_pkg.sv -----
// Shared types and constants for the tick energy time accumulator.
package tetacc_pkg;

   localparam int unsigned PRESCALE_W = 7;
   localparam int unsigned TIMEOUT_W  = 9;
   localparam int unsigned TICKS_W    = 8;
   localparam int unsigned UNITS_W    = 6;
   localparam int unsigned HOURS_W    = 16;
   localparam int unsigned LEVEL_W    = 8;
   localparam int unsigned SUM_W      = 10;
   localparam int unsigned PRODUCT_W  = 16;
   localparam int unsigned NUM_CHAN   = 3;

   localparam logic [PRESCALE_W-1:0] SCAN_TICKS    = 7'd100;
   localparam logic [TIMEOUT_W-1:0]  MAINS_TICKS   = 9'd500;
   localparam logic [PRODUCT_W-1:0]  PRODUCT_LIMIT = 16'd30000;
   localparam logic [UNITS_W:0]      UNITS_WRAP    = 7'd60;

   typedef enum logic [1:0] {
      ACT_TICK        = 2'd0,
      ACT_MAINS       = 2'd1,
      ACT_SCAN_TAKEN  = 2'd2,
      ACT_RECORD_TAKEN = 2'd3
   } action_type;

   typedef struct packed {
      action_type action;
      logic       signal_level;
      logic       chan1_on;
      logic       chan2_on;
      logic       chan3_on;
      logic       heat_alarm;
   } req_type;

   typedef struct packed {
      logic               signal_seen;
      logic               scan_request;
      logic               mains_present;
      logic               record_request;
      logic [UNITS_W-1:0] run_seconds;
      logic [UNITS_W-1:0] run_minutes;
      logic [HOURS_W-1:0] run_hours;
   } rsp_type;

   // Control from the tick unit to the energy unit
   typedef struct packed {
      logic tick;
      logic count_en;
      logic record_take;
   } ctl_type;

endpackage

// ----- hdl/tetacc_tick.sv -----
// Tick unit: pin sample, scan prescaler and mains timeout.
module tetacc_tick import tetacc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output ctl_type ctl,
   output logic    signal_seen_in,
   output logic    scan_request_in,
   output logic    mains_present_in
);

   logic [PRESCALE_W-1:0] prescale_ff, prescale_in, prescale_inc;
   logic [TIMEOUT_W-1:0]  timeout_ff, timeout_in, timeout_inc;
   logic                  signal_ff, scan_ff, mains_ff;

   assign prescale_inc = prescale_ff + PRESCALE_W'(1);
   assign timeout_inc  = timeout_ff + TIMEOUT_W'(1);

   always_comb begin
      prescale_in      = prescale_ff;
      timeout_in       = timeout_ff;
      signal_seen_in   = signal_ff;
      scan_request_in  = scan_ff;
      mains_present_in = mains_ff;
      ctl.tick         = 1'b0;
      ctl.record_take  = 1'b0;
      unique case (req.action)
         ACT_TICK: begin
            ctl.tick       = 1'b1;
            signal_seen_in = req.signal_level;
            if (!scan_ff) begin
               if (prescale_inc >= SCAN_TICKS) begin
                  prescale_in     = '0;
                  scan_request_in = 1'b1;
               end else begin
                  prescale_in = prescale_inc;
               end
            end
            if (mains_ff) begin
               // expire the mark; counting is skipped on this same tick
               if (timeout_inc >= MAINS_TICKS) begin
                  timeout_in       = '0;
                  mains_present_in = 1'b0;
               end else begin
                  timeout_in = timeout_inc;
               end
            end
         end
         ACT_MAINS:        mains_present_in = 1'b1;
         ACT_SCAN_TAKEN:   scan_request_in  = 1'b0;
         ACT_RECORD_TAKEN: ctl.record_take  = 1'b1;
         default:          ctl.record_take  = 1'b0;
      endcase
      ctl.count_en = ctl.tick && mains_present_in && !req.heat_alarm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         timeout_ff  <= '0;
         signal_ff   <= 1'b0;
         scan_ff     <= 1'b0;
         mains_ff    <= 1'b0;
      end else if (accept) begin
         prescale_ff <= prescale_in;
         timeout_ff  <= timeout_in;
         signal_ff   <= signal_seen_in;
         scan_ff     <= scan_request_in;
         mains_ff    <= mains_present_in;
      end
   end

endmodule

// ----- hdl/tetacc_energy.sv -----
// Energy unit: channel tick counters, weighted product and time cascade.
module tetacc_energy import tetacc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  req_type            req,
   input  ctl_type            ctl,
   input  logic [LEVEL_W-1:0] weight,
   output logic               record_request_in,
   output logic [UNITS_W-1:0] seconds_in,
   output logic [UNITS_W-1:0] minutes_in,
   output logic [HOURS_W-1:0] hours_in
);

   logic [TICKS_W-1:0]           ticks_ff [NUM_CHAN];
   logic [TICKS_W-1:0]           ticks_in [NUM_CHAN];
   logic [TICKS_W-1:0]           ticks_inc [NUM_CHAN];
   logic [NUM_CHAN-1:0]          chan_on;
   logic [SUM_W-1:0]             sum;
   logic [SUM_W+LEVEL_W-1:0]     product;
   logic                         roll;
   logic [UNITS_W:0]             sec_inc, min_inc;
   logic                         record_ff;
   logic [UNITS_W-1:0]           seconds_ff, minutes_ff;
   logic [HOURS_W-1:0]           hours_ff;

   assign chan_on = {req.chan3_on, req.chan2_on, req.chan1_on};

   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         ticks_inc[k] = ticks_ff[k] + TICKS_W'(ctl.count_en && chan_on[k]);
      end
      sum     = SUM_W'(ticks_inc[0]) + SUM_W'(ticks_inc[1]) + SUM_W'(ticks_inc[2]);
      product = SUM_W'(sum) * weight;
      roll    = ctl.tick && (product[PRODUCT_W-1:0] >= PRODUCT_LIMIT);
      sec_inc = {1'b0, seconds_ff} + (UNITS_W+1)'(1);
      min_inc = {1'b0, minutes_ff} + (UNITS_W+1)'(1);

      for (int k = 0; k < NUM_CHAN; k++) begin
         ticks_in[k] = ctl.tick ? (roll ? '0 : ticks_inc[k]) : ticks_ff[k];
      end
      record_request_in = ctl.record_take ? 1'b0 : record_ff;
      seconds_in        = seconds_ff;
      minutes_in        = minutes_ff;
      hours_in          = hours_ff;
      // advance the cascade: seconds, then minutes, then hours
      if (roll) begin
         if (sec_inc >= UNITS_WRAP) begin
            seconds_in        = '0;
            record_request_in = 1'b1;
            if (min_inc >= UNITS_WRAP) begin
               minutes_in = '0;
               hours_in   = hours_ff + HOURS_W'(1);
            end else begin
               minutes_in = min_inc[UNITS_W-1:0];
            end
         end else begin
            seconds_in = sec_inc[UNITS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CHAN; k++) begin
            ticks_ff[k] <= '0;
         end
         record_ff  <= 1'b0;
         seconds_ff <= '0;
         minutes_ff <= '0;
         hours_ff   <= '0;
      end else if (accept) begin
         for (int k = 0; k < NUM_CHAN; k++) begin
            ticks_ff[k] <= ticks_in[k];
         end
         record_ff  <= record_request_in;
         seconds_ff <= seconds_in;
         minutes_ff <= minutes_in;
         hours_ff   <= hours_in;
      end
   end

endmodule

// ----- hdl/tick_energy_time_accumulator.sv -----
// Top level of the tick energy time accumulator with handshakes and result register.
//
//   channel | ports                          | carries
//   --------+--------------------------------+--------------------------------
//   req     | req_valid, req_ready, req_payload | one action with pin and enables
//   rsp     | rsp_valid, rsp_ready, rsp_payload | flags and run time after it
//   csr     | csr_valid, csr_ready, csr_data  | power level weight
//
// State and the result register update at the accepting edge and the
// result is offered on the next cycle.
// A new request is taken every cycle while the result is taken or absent.
// A stalled result holds in the register and blocks further requests.
// Synchronous reset clears all counters, flags and the power level.
module tick_energy_time_accumulator import tetacc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_payload,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LEVEL_W-1:0] csr_data
);

   logic               accept;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [LEVEL_W-1:0] weight_ff;
   ctl_type            ctl;
   logic               signal_seen_in, scan_request_in, mains_present_in;
   logic               record_request_in;
   logic [UNITS_W-1:0] seconds_in, minutes_in;
   logic [HOURS_W-1:0] hours_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   tetacc_tick u_tick (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req              (req_payload),
      .ctl              (ctl),
      .signal_seen_in   (signal_seen_in),
      .scan_request_in  (scan_request_in),
      .mains_present_in (mains_present_in)
   );

   tetacc_energy u_energy (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req               (req_payload),
      .ctl               (ctl),
      .weight            (weight_ff),
      .record_request_in (record_request_in),
      .seconds_in        (seconds_in),
      .minutes_in        (minutes_in),
      .hours_in          (hours_in)
   );

   always_comb begin
      rsp_in.signal_seen    = signal_seen_in;
      rsp_in.scan_request   = scan_request_in;
      rsp_in.mains_present  = mains_present_in;
      rsp_in.record_request = record_request_in;
      rsp_in.run_seconds    = seconds_in;
      rsp_in.run_minutes    = minutes_in;
      rsp_in.run_hours      = hours_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         weight_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            weight_ff <= csr_data;
         end
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- bench/tick_energy_time_accumulator_tb.sv -----
// Self-checking bench for the tick energy time accumulator: directed table, then random phases.
`timescale 1ns / 1ps

module tick_energy_time_accumulator_tb;
   import tetacc_pkg::*;

   localparam int IDLE_LIMIT  = 1000;
   localparam int PHASE_ITEMS = 205;

   typedef struct {
      req_type item;
      bit      pinned;
      rsp_type want;
   } table_row_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_payload;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [LEVEL_W-1:0] csr_data = '0;

   tick_energy_time_accumulator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state
   logic [LEVEL_W-1:0]    lvl_q;
   logic                  sig_q, scan_q, mains_q, rec_q;
   logic [PRESCALE_W-1:0] prescale_q;
   logic [TIMEOUT_W-1:0]  timeout_q;
   logic [TICKS_W-1:0]    chan_q [NUM_CHAN];
   logic [UNITS_W-1:0]    sec_q, min_q;
   logic [HOURS_W-1:0]    hr_q;

   rsp_type pending_rsp [$];
   bit      pin_on = 1'b0;
   rsp_type pin_want = '0;

   int err_count   = 0;
   int n_req       = 0;
   int n_rsp       = 0;
   int n_levels    = 0;
   int n_seconds   = 0;
   int n_minutes   = 0;
   int n_expiries  = 0;
   int idle_cycles = 0;

   int seg_left   = 0;
   int seg_pos    = 0;
   int stall_mode = 0;
   int burst_left = 1;

   function automatic rsp_type next_response(req_type r);
      logic [SUM_W-1:0] sum;
      logic [17:0]      prod_full;
      logic [PRODUCT_W-1:0] product;
      rsp_type          res;
      case (r.action)
         ACT_TICK: begin
            sig_q = r.signal_level;
            if (!scan_q) begin
               prescale_q = prescale_q + 1'b1;
               if (prescale_q >= SCAN_TICKS) begin
                  prescale_q = '0;
                  scan_q = 1'b1;
               end
            end
            if (mains_q) begin
               timeout_q = timeout_q + 1'b1;
               if (timeout_q >= MAINS_TICKS) begin
                  timeout_q = '0;
                  mains_q = 1'b0;
                  n_expiries++;
               end
            end
            // expiry tick already skips counting
            if (mains_q && !r.heat_alarm) begin
               if (r.chan1_on) chan_q[0] = chan_q[0] + 1'b1;
               if (r.chan2_on) chan_q[1] = chan_q[1] + 1'b1;
               if (r.chan3_on) chan_q[2] = chan_q[2] + 1'b1;
            end
            sum = SUM_W'(chan_q[0]) + SUM_W'(chan_q[1]) + SUM_W'(chan_q[2]);
            prod_full = 18'(sum) * 18'(lvl_q);
            product = prod_full[PRODUCT_W-1:0];
            if (product >= PRODUCT_LIMIT) begin
               for (int k = 0; k < NUM_CHAN; k++) chan_q[k] = '0;
               n_seconds++;
               sec_q = sec_q + 1'b1;
               if (sec_q >= UNITS_WRAP) begin
                  sec_q = '0;
                  rec_q = 1'b1;
                  n_minutes++;
                  min_q = min_q + 1'b1;
                  if (min_q >= UNITS_WRAP) begin
                     min_q = '0;
                     hr_q = hr_q + 1'b1;
                  end
               end
            end
         end
         ACT_MAINS:      mains_q = 1'b1;
         ACT_SCAN_TAKEN: scan_q = 1'b0;
         default:        rec_q = 1'b0;
      endcase
      res.signal_seen    = sig_q;
      res.scan_request   = scan_q;
      res.mains_present  = mains_q;
      res.record_request = rec_q;
      res.run_seconds    = sec_q;
      res.run_minutes    = min_q;
      res.run_hours      = hr_q;
      return res;
   endfunction

   function automatic table_row_t mk_row(action_type a, logic [4:0] pins, bit pinned,
                                         logic [3:0] flg);
      table_row_t row;
      row.item   = req_type'({a, pins});
      row.pinned = pinned;
      row.want   = rsp_type'({flg, 28'd0});
      return row;
   endfunction

   // Sample both channels and the register port at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         lvl_q = '0;
         sig_q = 1'b0;
         scan_q = 1'b0;
         mains_q = 1'b0;
         rec_q = 1'b0;
         prescale_q = '0;
         timeout_q = '0;
         for (int k = 0; k < NUM_CHAN; k++) chan_q[k] = '0;
         sec_q = '0;
         min_q = '0;
         hr_q = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            got = rsp_payload;
            if (pending_rsp.size() == 0) begin
               $error("response with no request outstanding: %h", got);
               err_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (got.signal_seen !== want.signal_seen) begin
                  $error("signal_seen: expected %0d, got %0d", want.signal_seen, got.signal_seen);
                  err_count++;
               end
               if (got.scan_request !== want.scan_request) begin
                  $error("scan_request: expected %0d, got %0d",
                         want.scan_request, got.scan_request);
                  err_count++;
               end
               if (got.mains_present !== want.mains_present) begin
                  $error("mains_present: expected %0d, got %0d",
                         want.mains_present, got.mains_present);
                  err_count++;
               end
               if (got.record_request !== want.record_request) begin
                  $error("record_request: expected %0d, got %0d",
                         want.record_request, got.record_request);
                  err_count++;
               end
               if (got.run_seconds !== want.run_seconds) begin
                  $error("run_seconds: expected %0d, got %0d", want.run_seconds, got.run_seconds);
                  err_count++;
               end
               if (got.run_minutes !== want.run_minutes) begin
                  $error("run_minutes: expected %0d, got %0d", want.run_minutes, got.run_minutes);
                  err_count++;
               end
               if (got.run_hours !== want.run_hours) begin
                  $error("run_hours: expected %0d, got %0d", want.run_hours, got.run_hours);
                  err_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            n_req++;
            want = next_response(req_payload);
            pending_rsp.push_back(pin_on ? pin_want : want);
         end
         if (csr_valid && csr_ready) begin
            lvl_q = csr_data;
            n_levels++;
         end
      end
   end

   // Watchdog: count cycles in which no handshake completes
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver stall pattern: segments of always-ready, mostly-ready, mostly-stalled, periodic
   always @(negedge clock) begin
      if (seg_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         seg_left = $urandom_range(8, 80);
         seg_pos = 0;
      end
      seg_left--;
      seg_pos++;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ((seg_pos % 7) >= 3);
      endcase
   end

   // Present one request from a falling edge; return at the falling edge after acceptance, or later when a burst ends
   task automatic push_request(req_type item, bit pinned, rsp_type want);
      int gap;
      pin_on = pinned;
      pin_want = want;
      req_payload <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      pin_on = 1'b0;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic write_level(logic [LEVEL_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      table_row_t   rows [$];
      req_type      item;
      int           roll;
      logic [LEVEL_W-1:0] levels [8];

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table, power level still at its reset value of zero
      rows.push_back(mk_row(ACT_TICK,         5'b10000, 1'b1, 4'b1000));
      rows.push_back(mk_row(ACT_TICK,         5'b00000, 1'b1, 4'b0000));
      rows.push_back(mk_row(ACT_TICK,         5'b11111, 1'b1, 4'b1000));
      rows.push_back(mk_row(ACT_MAINS,        5'b00000, 1'b1, 4'b1010));
      rows.push_back(mk_row(ACT_MAINS,        5'b11111, 1'b1, 4'b1010));
      rows.push_back(mk_row(ACT_SCAN_TAKEN,   5'b11111, 1'b1, 4'b1010));
      rows.push_back(mk_row(ACT_RECORD_TAKEN, 5'b11111, 1'b1, 4'b1010));
      rows.push_back(mk_row(ACT_TICK,         5'b01110, 1'b1, 4'b0010));
      rows.push_back(mk_row(ACT_TICK,         5'b01111, 1'b1, 4'b0010));
      rows.push_back(mk_row(ACT_TICK,         5'b10001, 1'b1, 4'b1010));
      rows.push_back(mk_row(ACT_TICK,         5'b11110, 1'b0, 4'b0000));
      rows.push_back(mk_row(ACT_TICK,         5'b00100, 1'b0, 4'b0000));
      rows.push_back(mk_row(ACT_RECORD_TAKEN, 5'b00000, 1'b0, 4'b0000));
      rows.push_back(mk_row(ACT_SCAN_TAKEN,   5'b00000, 1'b0, 4'b0000));
      rows.push_back(mk_row(ACT_TICK,         5'b11010, 1'b0, 4'b0000));
      foreach (rows[i]) push_request(rows[i].item, rows[i].pinned, rows[i].want);

      // A low weight lets the counters wrap; a high one afterwards hits truncation
      levels = '{8'd255, 8'd39, 8'd255, 8'd0, 8'd1, 8'd128,
                 8'($urandom_range(2, 254)), 8'd255};
      foreach (levels[p]) begin
         write_level(levels[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               item = req_type'(7'($urandom_range(0, 127)));
            end else begin
               roll = $urandom_range(0, 99);
               item.action = (roll < 84) ? ACT_TICK :
                             (roll < 91) ? ACT_MAINS :
                             (roll < 96) ? ACT_SCAN_TAKEN : ACT_RECORD_TAKEN;
               item.signal_level = 1'($urandom_range(0, 1));
               item.chan1_on = ($urandom_range(0, 7) != 0);
               item.chan2_on = ($urandom_range(0, 7) != 0);
               item.chan3_on = ($urandom_range(0, 7) != 0);
               item.heat_alarm = ($urandom_range(0, 7) == 0);
            end
            push_request(item, 1'b0, '0);
         end
      end

      // Drain and let the result register settle
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);

      $display("Run covered %0d requests, %0d responses, %0d power level writes",
               n_req, n_rsp, n_levels);
      $display("Predicted %0d second steps, %0d minute records, %0d mains expiries",
               n_seconds, n_minutes, n_expiries);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- tick_energy_time_accumulator.f -----
hdl/tetacc_pkg.sv
hdl/tetacc_tick.sv
hdl/tetacc_energy.sv
hdl/tick_energy_time_accumulator.sv
bench/tick_energy_time_accumulator_tb.sv
